[rtl/core/zsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsf_pkg
// Shared constants and types of the zero-sum subarray finder: widths, cell
// count, picker geometry, cell control bundle and control states.
// ----------------------------------------------------------------------------
package zsf_pkg;

    // element and sum widths
    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS   = VALUE_BITS + 6;

    // index width and table capacity
    localparam int IDX_BITS  = 6;
    localparam int MAX_ITEMS = 63;

    // cells hold prefix positions 1 .. MAX_ITEMS-1, position 0 is always zero
    localparam int NUM_CELLS = MAX_ITEMS - 1;

    // match picker geometry: groups of eight bits
    localparam int PICK_BITS  = 1 << IDX_BITS;
    localparam int GRP_BITS   = 3;
    localparam int GROUP_SIZE = 1 << GRP_BITS;
    localparam int SEL_BITS   = IDX_BITS - GRP_BITS;
    localparam int NUM_GROUPS = 1 << SEL_BITS;

    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [IDX_BITS-1:0] idx_t;

    // broadcast control to every cell
    typedef struct packed {
        logic compare;
        logic clear;
    } cell_ctrl_t;

    // picker result
    typedef struct packed {
        logic any;
        logic more;
        idx_t idx;
    } pick_t;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EMIT
    } state_t;

endpackage

[rtl/core/zero_sum_subarray_finder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_sum_subarray_finder_top
// Zero-sum subarray finder built as a chain of prefix-sum cells.
//
// Input channel (in_valid / in_stall): one signed array element per request,
// last_item marks the final element of an array. Output channel
// (out_valid / out_stall): one request per zero-sum subarray ending at the
// current element, as start_index and end_index, in ascending start order;
// last_match flags the final one for that element.
// Timing: an element is taken in the idle state; the next cycle compares the
// new prefix sum against every stored cell in parallel and stores it in the
// first free cell. Results then leave one per cycle from the match picker
// while out_stall is low. The next element is taken only once the emit state
// returns to idle; the first result appears in the emit state, after compare.
// Elements beyond 63 in one array are taken and ignored.
// A stalled result holds its fields and further results wait behind it.
// Reset (rst_n low, asynchronous) empties all cells and clears the sum and
// count; an element with last_item set does the same after its results.
// ----------------------------------------------------------------------------
module zero_sum_subarray_finder_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [zsf_pkg::VALUE_BITS-1:0] value,
    input  logic                                 last_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [zsf_pkg::IDX_BITS-1:0]         start_index,
    output logic [zsf_pkg::IDX_BITS-1:0]         end_index,
    output logic                                 last_match
);
    import zsf_pkg::*;

    state_t state_reg;
    state_t state_next;
    sum_t   sum_reg;
    sum_t   sum_next;
    idx_t   count_reg;
    idx_t   count_next;
    idx_t   cur_idx_reg;
    idx_t   cur_idx_next;
    logic   last_reg;
    logic   last_next;
    logic   match0_reg;
    logic   match0_next;

    cell_ctrl_t             ctrl;
    logic                   in_fire;
    logic                   out_fire;
    logic                   room;
    logic                   finish;
    logic [NUM_CELLS:0]     occ_chain;
    logic [MAX_ITEMS-1:0]   match_vec;
    logic [MAX_ITEMS-1:0]   onehot;
    logic [MAX_ITEMS-1:0]   grant_vec;
    pick_t                  pick;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign room     = count_reg < IDX_BITS'(MAX_ITEMS);
    assign finish   = (state_reg == ST_EMIT) && (!pick.any || (!out_stall && !pick.more));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && room)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        ctrl.compare = 1'b0;
        ctrl.clear   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                ctrl.clear = in_valid && !room && last_item;
            end
            ST_CMP:
            begin
                ctrl.compare = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid  = pick.any;
                ctrl.clear = finish && last_reg;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        cur_idx_next = cur_idx_reg;
        last_next    = last_reg;
        match0_next  = match0_reg;
        if (in_fire && room)
        begin
            sum_next     = sum_reg + {{(SUM_BITS-VALUE_BITS){value[VALUE_BITS-1]}}, value};
            cur_idx_next = count_reg;
            count_next   = count_reg + 1'b1;
            last_next    = last_item;
        end
        if (ctrl.compare)
        begin
            match0_next = (sum_reg == '0);
        end
        else if (grant_vec[0])
        begin
            match0_next = 1'b0;
        end
        if (ctrl.clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
    end

    // control and datapath flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sum_reg    <= '0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
            match0_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            match0_reg <= match0_next;
        end
    end

    // current element index
    always_ff @(posedge clk)
    begin
        cur_idx_reg <= cur_idx_next;
    end

    // chain of prefix cells, position 0 is the fixed empty prefix
    assign occ_chain[0]  = 1'b1;
    assign match_vec[0]  = match0_reg;
    assign grant_vec     = out_fire ? onehot : '0;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        zsf_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sum_in   (sum_reg),
            .prev_occ (occ_chain[k]),
            .grant    (grant_vec[k+1]),
            .occ      (occ_chain[k+1]),
            .match    (match_vec[k+1])
        );
    end

    // lowest pending match
    zsf_pick u_pick
    (
        .match_vec (match_vec),
        .pick      (pick),
        .onehot    (onehot)
    );

    assign start_index = pick.idx;
    assign end_index   = cur_idx_reg;
    assign last_match  = !pick.more;

`ifndef ASSERT_OFF
    // final result of an element returns the block to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_match) |=> (state_reg == ST_IDLE))
        else $error("final result did not end the element");

    // occupied cells always form a contiguous run from the head
    a_occ_contig: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_chain[NUM_CELLS:1] & (occ_chain[NUM_CELLS:1] + 1'b1)) == '0))
        else $error("cell occupancy is not contiguous");

    // a subarray never starts after its end
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_index <= end_index))
        else $error("start index beyond end index");

    // at most one cell released per result
    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one match released");
`endif

endmodule

[rtl/core/zsf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsf_cell
// One prefix-sum cell: stores a sum when it is the first free cell of the
// chain, compares it with the broadcast sum, and holds its match flag until
// the result for it is granted.
// ----------------------------------------------------------------------------
module zsf_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  zsf_pkg::cell_ctrl_t ctrl,
    input  zsf_pkg::sum_t       sum_in,
    input  logic                prev_occ,
    input  logic                grant,
    output logic                occ,
    output logic                match
);
    import zsf_pkg::*;

    logic occ_reg;
    logic occ_next;
    logic match_reg;
    logic match_next;
    sum_t stored_reg;
    logic load;

    // first free cell behind an occupied neighbor takes the new sum
    assign load = ctrl.compare && prev_occ && !occ_reg;

    // occupancy and match next values
    always_comb
    begin
        occ_next   = occ_reg;
        match_next = match_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (load)
        begin
            occ_next = 1'b1;
        end
        if (ctrl.compare)
        begin
            match_next = occ_reg && (stored_reg == sum_in);
        end
        else if (grant)
        begin
            match_next = 1'b0;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            match_reg <= match_next;
        end
    end

    // stored prefix sum
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stored_reg <= sum_in;
        end
    end

    assign occ   = occ_reg;
    assign match = match_reg;

endmodule

[rtl/core/zsf_pick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsf_pick
// Lowest-index match picker: a two-level find-first over groups of eight,
// giving the index, a one-hot grant mask and whether more matches remain.
// ----------------------------------------------------------------------------
module zsf_pick
(
    input  logic [zsf_pkg::MAX_ITEMS-1:0] match_vec,
    output zsf_pkg::pick_t                pick,
    output logic [zsf_pkg::MAX_ITEMS-1:0] onehot
);
    import zsf_pkg::*;

    logic [PICK_BITS-1:0]  vec_pad;
    logic [PICK_BITS-1:0]  onehot_pad;
    logic [NUM_GROUPS-1:0] grp_any;
    logic [GROUP_SIZE-1:0] sub_vec;
    logic [SEL_BITS-1:0]   sel_grp;
    logic [GRP_BITS-1:0]   sel_bit;
    idx_t                  pick_idx;

    assign vec_pad = {{(PICK_BITS-MAX_ITEMS){1'b0}}, match_vec};

    // group summary and lowest nonempty group
    always_comb
    begin
        sel_grp = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any[g] = |vec_pad[g*GROUP_SIZE +: GROUP_SIZE];
        end
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                sel_grp = SEL_BITS'(g);
            end
        end
    end

    // lowest set bit inside the chosen group
    assign sub_vec = vec_pad[{sel_grp, {GRP_BITS{1'b0}}} +: GROUP_SIZE];

    always_comb
    begin
        sel_bit = '0;
        for (int b = GROUP_SIZE - 1; b >= 0; b--)
        begin
            if (sub_vec[b])
            begin
                sel_bit = GRP_BITS'(b);
            end
        end
    end

    assign pick_idx   = {sel_grp, sel_bit};
    assign onehot_pad = PICK_BITS'(1) << pick_idx;

    // result bundle
    assign pick.any  = |grp_any;
    assign pick.more = |(vec_pad & ~onehot_pad);
    assign pick.idx  = pick_idx;
    assign onehot    = onehot_pad[MAX_ITEMS-1:0];

endmodule
